// ===== hw/rtl/bpc_pkg.sv =====
// Shared types and constants for the barometric pressure compensation core.
package bpc_pkg;

    // Field and intermediate widths
    localparam int D_W       = 24;
    localparam int COEF_W    = 16;
    localparam int OFF_W     = 37;
    localparam int SENS_W    = 36;
    localparam int SENS_LO_W = 18;
    localparam int P_W       = 32;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_PROM_WORD0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_SENS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_OFF    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SENS_TCO     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_TCO      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_TEMP     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_SLOPE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST         = CFG_TEMP_SLOPE;

    // CRC-4 over the calibration words
    localparam logic [15:0] CRC_POLY        = 16'h3000;
    localparam logic [15:0] CRC_TOP_BIT     = 16'h8000;
    localparam logic [15:0] CRC_CLEAR_MASK  = 16'h0FFF;
    localparam logic [15:0] CRC_NIBBLE_MASK = 16'hF000;
    localparam int          CRC_CNT_W       = 4;
    localparam logic [CRC_CNT_W-1:0] CRC_LAST_BYTE = 4'd15;

    // Input beat
    typedef struct packed {
        logic [D_W-1:0] pressure_raw;
        logic [D_W-1:0] temperature_raw;
    } t_in_beat;

    // Result beat
    typedef struct packed {
        logic signed [P_W-1:0] pressure;
        logic                  calibration_ok;
    } t_out_beat;

    // Calibration register file contents
    typedef struct packed {
        logic [COEF_W-1:0] prom_word0;
        logic [COEF_W-1:0] pressure_sensitivity;
        logic [COEF_W-1:0] pressure_offset;
        logic [COEF_W-1:0] sens_temp_coeff;
        logic [COEF_W-1:0] offset_temp_coeff;
        logic [COEF_W-1:0] reference_temperature;
        logic [COEF_W-1:0] temperature_slope;
    } t_calib;

    // Front half to back half of the datapath
    typedef struct packed {
        logic [D_W-1:0]           d1;
        logic signed [OFF_W-1:0]  off;
        logic signed [SENS_W-1:0] sens;
    } t_front_beat;

    // CRC checker status
    typedef struct packed {
        logic busy;
        logic ok;
    } t_crc_status;

endpackage

// ===== hw/rtl/bpc_crc4.sv =====
// CRC-4 checker that walks the calibration bytes one per cycle.
module bpc_crc4 (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_restart,
    input  bpc_pkg::t_calib      i_calib,
    output bpc_pkg::t_crc_status o_status
);
    import bpc_pkg::*;

    logic                 r_run;
    logic [CRC_CNT_W-1:0] r_idx;
    logic [15:0]          r_rem;
    logic                 r_ok;
    logic [15:0]          n_rem;
    logic [15:0]          w_word;
    logic [7:0]           w_byte;

    // Shift one byte through the remainder
    function automatic logic [15:0] crc_byte_step(input logic [15:0] rem_in);
        logic [15:0] r;
        r = rem_in;
        for (int b = 0; b < 8; b++) begin
            if ((r & CRC_TOP_BIT) != 16'h0000) begin
                r = (r << 1) ^ CRC_POLY;
            end else begin
                r = r << 1;
            end
        end
        return r;
    endfunction

    // Pick the calibration word, high byte first
    always_comb begin
        case (r_idx[CRC_CNT_W-1:1])
            3'd0:    w_word = i_calib.prom_word0 & CRC_CLEAR_MASK;
            3'd1:    w_word = i_calib.pressure_sensitivity;
            3'd2:    w_word = i_calib.pressure_offset;
            3'd3:    w_word = i_calib.sens_temp_coeff;
            3'd4:    w_word = i_calib.offset_temp_coeff;
            3'd5:    w_word = i_calib.reference_temperature;
            3'd6:    w_word = i_calib.temperature_slope;
            default: w_word = 16'h0000;
        endcase
        w_byte = r_idx[0] ? w_word[7:0] : w_word[15:8];
        n_rem  = crc_byte_step(r_rem ^ {8'h00, w_byte});
    end

    // Advance one byte per cycle; restart on any calibration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b1;
            r_idx <= '0;
            r_rem <= 16'h0000;
            r_ok  <= 1'b0;
        end else if (i_restart) begin
            r_run <= 1'b1;
            r_idx <= '0;
            r_rem <= 16'h0000;
        end else if (r_run) begin
            r_rem <= n_rem;
            r_idx <= r_idx + 1'b1;
            if (r_idx == CRC_LAST_BYTE) begin
                r_run <= 1'b0;
                r_ok  <= (n_rem & CRC_NIBBLE_MASK) == (i_calib.prom_word0 & CRC_NIBBLE_MASK);
            end
        end
    end

    assign o_status.busy = r_run;
    assign o_status.ok   = r_ok;

endmodule

// ===== hw/rtl/bpc_front.sv =====
// Front half of the datapath: dT, temperature products, offset and sensitivity.
module bpc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  bpc_pkg::t_in_beat    i_in,
    input  bpc_pkg::t_calib      i_calib,
    output logic                 o_valid,
    output bpc_pkg::t_front_beat o_beat
);
    import bpc_pkg::*;

    // Stage 1: temperature difference
    logic                 r_v1;
    logic [D_W-1:0]       r_d1_s1;
    logic signed [24:0]   r_dt;
    logic signed [24:0]   n_dt;
    // Stage 2: coefficient products
    logic                 r_v2;
    logic [D_W-1:0]       r_d1_s2;
    logic signed [41:0]   r_m3;
    logic signed [41:0]   r_m4;
    logic signed [41:0]   n_m3;
    logic signed [41:0]   n_m4;
    // Stage 3: offset and sensitivity
    logic                 r_v3;
    t_front_beat          r_beat;
    t_front_beat          n_beat;

    assign n_dt = $signed({1'b0, i_in.temperature_raw})
                - $signed({1'b0, i_calib.reference_temperature, 8'h00});

    assign n_m3 = $signed({1'b0, i_calib.sens_temp_coeff}) * r_dt;
    assign n_m4 = $signed({1'b0, i_calib.offset_temp_coeff}) * r_dt;

    // Floor shifts are plain bit selects of the two's complement products
    always_comb begin
        n_beat.d1   = r_d1_s2;
        n_beat.off  = $signed({4'b0000, i_calib.pressure_offset, 17'h00000})
                    + $signed({r_m4[41], r_m4[41:6]});
        n_beat.sens = $signed({4'b0000, i_calib.pressure_sensitivity, 16'h0000})
                    + $signed({r_m3[41], r_m3[41:7]});
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        r_d1_s1 <= i_in.pressure_raw;
        r_dt    <= n_dt;
        r_d1_s2 <= r_d1_s1;
        r_m3    <= n_m3;
        r_m4    <= n_m4;
        r_beat  <= n_beat;
    end

    assign o_valid = r_v3;
    assign o_beat  = r_beat;

endmodule

// ===== hw/rtl/bpc_back.sv =====
// Back half of the datapath: D1 times sensitivity, offset removal, output register.
module bpc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  bpc_pkg::t_front_beat i_beat,
    input  logic                 i_crc_ok,
    output logic                 o_valid,
    output bpc_pkg::t_out_beat   o_out
);
    import bpc_pkg::*;

    // Stage 4: partial products of D1 and sensitivity
    logic                    r_v4;
    logic [41:0]             r_pl;
    logic signed [42:0]      r_ph;
    logic signed [OFF_W-1:0] r_off_s4;
    logic [41:0]             n_pl;
    logic signed [42:0]      n_ph;
    // Stage 5: full product, shifted down
    logic                    r_v5;
    logic signed [39:0]      r_prod_sh;
    logic signed [OFF_W-1:0] r_off_s5;
    logic signed [60:0]      n_prod;
    // Stage 6: subtract offset, shift, output register
    logic                    r_v6;
    t_out_beat               r_out;
    logic signed [39:0]      n_q;

    assign n_pl = i_beat.d1 * i_beat.sens[SENS_LO_W-1:0];
    assign n_ph = $signed({1'b0, i_beat.d1}) * $signed(i_beat.sens[SENS_W-1:SENS_LO_W]);

    assign n_prod = $signed({r_ph, 18'h00000}) + $signed({19'h00000, r_pl});

    assign n_q = r_prod_sh - $signed({{3{r_off_s5[OFF_W-1]}}, r_off_s5});

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            r_v4 <= i_valid;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        r_pl                 <= n_pl;
        r_ph                 <= n_ph;
        r_off_s4             <= i_beat.off;
        r_prod_sh            <= n_prod[60:21];
        r_off_s5             <= r_off_s4;
        r_out.pressure       <= {{7{n_q[39]}}, n_q[39:15]};
        r_out.calibration_ok <= i_crc_ok;
    end

    assign o_valid = r_v6;
    assign o_out   = r_out;

endmodule

// ===== hw/rtl/barometer_pressure_compensation_core.sv =====
// Top level of the barometric pressure compensation core.
// Takes one D1/D2 conversion pair per clock while busy is low and returns the
// compensated pressure with the calibration CRC flag through the six-stage
// datapath, strobed by o_valid for one cycle; the D1 times sensitivity multiply
// is split in two, and throughput is one beat a cycle while busy is low.
// The receiver cannot stall. After reset and after every write to a calibration
// register, busy stays high while the CRC-4 unit walks 16 bytes, the seven
// calibration words and a zero pad word, one per cycle; no beat is accepted then.
// Write calibration only while no beat is in flight.
module barometer_pressure_compensation_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  bpc_pkg::t_in_beat                i_in,
    output logic                             o_valid,
    output bpc_pkg::t_out_beat               o_out,
    input  logic                             i_cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bpc_pkg::COEF_W-1:0]       i_cfg_data
);
    import bpc_pkg::*;

    t_calib      r_calib;
    t_crc_status w_crc;
    t_front_beat w_front;
    logic        w_front_v;
    logic        w_accept;
    logic        w_cfg_hit;

    assign w_accept  = start && !w_crc.busy;
    assign w_cfg_hit = i_cfg_we && (i_cfg_idx <= CFG_LAST);

    // Hold calibration registers; drop writes beyond the last index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calib <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PROM_WORD0: r_calib.prom_word0            <= i_cfg_data;
                CFG_PRESS_SENS: r_calib.pressure_sensitivity  <= i_cfg_data;
                CFG_PRESS_OFF:  r_calib.pressure_offset       <= i_cfg_data;
                CFG_SENS_TCO:   r_calib.sens_temp_coeff       <= i_cfg_data;
                CFG_OFF_TCO:    r_calib.offset_temp_coeff     <= i_cfg_data;
                CFG_REF_TEMP:   r_calib.reference_temperature <= i_cfg_data;
                CFG_TEMP_SLOPE: r_calib.temperature_slope     <= i_cfg_data;
                default:        r_calib <= r_calib;
            endcase
        end
    end

    bpc_crc4 u_crc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (w_cfg_hit),
        .i_calib   (r_calib),
        .o_status  (w_crc)
    );

    bpc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_in    (i_in),
        .i_calib (r_calib),
        .o_valid (w_front_v),
        .o_beat  (w_front)
    );

    bpc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_front_v),
        .i_beat   (w_front),
        .i_crc_ok (w_crc.ok),
        .o_valid  (o_valid),
        .o_out    (o_out)
    );

    assign busy = w_crc.busy;

endmodule

// ===== hw/rtl/bpc_checker.sv =====
// Port-level checker for the compensation core and its bind.
module bpc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_valid,
    input logic                          i_cfg_we,
    input logic [bpc_pkg::CFG_IDX_W-1:0] i_cfg_idx
);
    import bpc_pkg::*;

    // Every accepted beat yields a result
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##6 o_valid)
        else $error("accepted beat produced no result");

    // No result without a matching accepted beat
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 6))
        else $error("result without matching start beat");

    // A calibration write reruns the CRC check
    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (i_cfg_idx <= CFG_LAST)) |=> busy)
        else $error("calibration write did not raise busy");

    // Leaving reset starts a CRC pass
    a_reset_busy: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> busy)
        else $error("busy low right after reset");

endmodule

bind barometer_pressure_compensation_core bpc_checker u_bpc_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .o_valid   (o_valid),
    .i_cfg_we  (i_cfg_we),
    .i_cfg_idx (i_cfg_idx)
);

// ===== bench/tb_barometer_pressure_compensation_core.sv =====
// Self-checking testbench for the barometric pressure compensation core.
module tb_barometer_pressure_compensation_core;
    timeunit 1ns;
    timeprecision 1ps;

    import bpc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 12;
    localparam int IDLE_PCT = 34;
    localparam int RANDOM_SETS = 10;
    localparam int BEATS_PER_SET = 55;
    // Index past the last register; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = CFG_IDX_W'(CFG_LAST + 1);

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    t_in_beat              i_in = '0;
    logic                  o_valid;
    t_out_beat             o_out;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [COEF_W-1:0]     i_cfg_data = '0;

    t_in_beat  pending_beats[$];
    t_out_beat expected_pressure[$];
    t_calib    calib_copy = '0;
    int        results_owed = 0;
    int        results_seen = 0;
    int        fail_count = 0;
    int        calib_sets = 0;
    int        cycle_count = 0;
    bit        steady_run = 1'b0;
    bit        beat_taken = 1'b0;

    barometer_pressure_compensation_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_in       (i_in),
        .o_valid    (o_valid),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // CRC-4 over the seven calibration words and a zero pad word, high byte first
    function automatic logic [3:0] calib_crc4(input t_calib c);
        logic [15:0] words [0:7];
        logic [15:0] rem;
        logic [7:0]  byte_in;
        words[0] = c.prom_word0 & CRC_CLEAR_MASK;
        words[1] = c.pressure_sensitivity;
        words[2] = c.pressure_offset;
        words[3] = c.sens_temp_coeff;
        words[4] = c.offset_temp_coeff;
        words[5] = c.reference_temperature;
        words[6] = c.temperature_slope;
        words[7] = 16'h0000;
        rem = 16'h0000;
        for (int i = 0; i < 16; i++) begin
            byte_in = i[0] ? words[i >> 1][7:0] : words[i >> 1][15:8];
            rem = rem ^ {8'h00, byte_in};
            for (int b = 0; b < 8; b++) begin
                if ((rem & CRC_TOP_BIT) != 0)
                    rem = (rem << 1) ^ CRC_POLY;
                else
                    rem = rem << 1;
            end
        end
        return rem[15:12];
    endfunction

    // First-order compensation with 64-bit floor shifts
    function automatic t_out_beat compensate(input t_in_beat b, input t_calib c);
        longint d1, d2, dt, off, sens, p;
        t_out_beat r;
        d1 = longint'(b.pressure_raw);
        d2 = longint'(b.temperature_raw);
        dt = d2 - longint'(c.reference_temperature) * 256;
        off = longint'(c.pressure_offset) * 131072
            + ((longint'(c.offset_temp_coeff) * dt) >>> 6);
        sens = longint'(c.pressure_sensitivity) * 65536
             + ((longint'(c.sens_temp_coeff) * dt) >>> 7);
        p = (((d1 * sens) >>> 21) - off) >>> 15;
        r.pressure = p[31:0];
        r.calibration_ok = (calib_crc4(c) == ((c.prom_word0 & CRC_NIBBLE_MASK) >> 12));
        return r;
    endfunction

    // Put a matching (or deliberately wrong) checksum into word zero
    function automatic t_calib seal_calib(input t_calib c, input bit corrupt);
        logic [3:0] crc;
        crc = calib_crc4(c);
        if (corrupt)
            crc = ~crc;
        c.prom_word0 = {crc, c.prom_word0[11:0]};
        return c;
    endfunction

    function automatic t_calib random_calib();
        t_calib c;
        c.prom_word0            = COEF_W'($urandom_range(16'hFFFF));
        c.pressure_sensitivity  = COEF_W'($urandom_range(16'hFFFF));
        c.pressure_offset       = COEF_W'($urandom_range(16'hFFFF));
        c.sens_temp_coeff       = COEF_W'($urandom_range(16'hFFFF));
        c.offset_temp_coeff     = COEF_W'($urandom_range(16'hFFFF));
        c.reference_temperature = COEF_W'($urandom_range(16'hFFFF));
        c.temperature_slope     = COEF_W'($urandom_range(16'hFFFF));
        return c;
    endfunction

    function automatic t_calib typical_calib();
        t_calib c;
        c.prom_word0            = 16'h0123;
        c.pressure_sensitivity  = 16'd40127;
        c.pressure_offset       = 16'd36924;
        c.sens_temp_coeff       = 16'd23317;
        c.offset_temp_coeff     = 16'd23282;
        c.reference_temperature = 16'd33464;
        c.temperature_slope     = 16'd28312;
        return c;
    endfunction

    // Write one register at the next falling edge and track it locally
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_PROM_WORD0: calib_copy.prom_word0            = val;
            CFG_PRESS_SENS: calib_copy.pressure_sensitivity  = val;
            CFG_PRESS_OFF:  calib_copy.pressure_offset       = val;
            CFG_SENS_TCO:   calib_copy.sens_temp_coeff       = val;
            CFG_OFF_TCO:    calib_copy.offset_temp_coeff     = val;
            CFG_REF_TEMP:   calib_copy.reference_temperature = val;
            CFG_TEMP_SLOPE: calib_copy.temperature_slope     = val;
            default: ;
        endcase
    endtask

    // Load a full calibration set, with a stray write to the unused index first
    task automatic load_calib(input t_calib c);
        write_reg(CFG_IDX_SPARE, COEF_W'($urandom_range(16'hFFFF)));
        write_reg(CFG_PROM_WORD0, c.prom_word0);
        write_reg(CFG_PRESS_SENS, c.pressure_sensitivity);
        write_reg(CFG_PRESS_OFF, c.pressure_offset);
        write_reg(CFG_SENS_TCO, c.sens_temp_coeff);
        write_reg(CFG_OFF_TCO, c.offset_temp_coeff);
        write_reg(CFG_REF_TEMP, c.reference_temperature);
        write_reg(CFG_TEMP_SLOPE, c.temperature_slope);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        calib_sets++;
    endtask

    task automatic queue_beat(input logic [D_W-1:0] d1, input logic [D_W-1:0] d2);
        t_in_beat b;
        b.pressure_raw    = d1;
        b.temperature_raw = d2;
        pending_beats.push_back(b);
        results_owed++;
    endtask

    // Mix of uniform, near-reference temperature and extreme pressure beats
    task automatic queue_random_beats(input int n);
        logic [D_W-1:0] d1, d2;
        int ref_t;
        for (int k = 0; k < n; k++) begin
            d1 = D_W'($urandom);
            d2 = D_W'($urandom);
            case ($urandom_range(3))
                1: begin
                    ref_t = int'(calib_copy.reference_temperature) * 256
                          + $urandom_range(4096) - 2048;
                    if (ref_t < 0)
                        ref_t = 0;
                    if (ref_t > 24'hFFFFFF)
                        ref_t = 24'hFFFFFF;
                    d2 = D_W'(ref_t);
                end
                2: d1 = $urandom_range(1) ? D_W'(24'hFFFFFF - $urandom_range(255))
                                          : D_W'($urandom_range(255));
                default: ;
            endcase
            queue_beat(d1, d2);
        end
    endtask

    // Hold off until every expected beat is back and the pipe is quiet
    task automatic drain();
        wait (results_owed == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Drive start and the input beat; advance only after a beat is taken
    always @(negedge i_clk) begin : drive_proc
        t_in_beat next_beat;
        logic     next_start;
        next_beat  = i_in;
        next_start = start;
        if (!i_rst_n) begin
            next_start = 1'b0;
        end else if (!start || beat_taken) begin
            next_start = 1'b0;
            if (pending_beats.size() > 0 &&
                (steady_run || $urandom_range(99) >= IDLE_PCT)) begin
                next_beat  = pending_beats.pop_front();
                next_start = 1'b1;
            end
        end
        start <= next_start;
        i_in  <= next_beat;
    end

    // Check results against the oldest prediction, then record new beats
    always @(posedge i_clk) begin : watch_proc
        t_out_beat want;
        beat_taken = 1'b0;
        if (i_rst_n) begin
            if (o_valid) begin
                if (expected_pressure.size() == 0) begin
                    $error("unexpected result beat: pressure %0d calibration_ok %0b",
                           o_out.pressure, o_out.calibration_ok);
                    fail_count++;
                end else begin
                    want = expected_pressure.pop_front();
                    if (o_out.pressure !== want.pressure) begin
                        $error("pressure: expected %0d, got %0d",
                               want.pressure, o_out.pressure);
                        fail_count++;
                    end
                    if (o_out.calibration_ok !== want.calibration_ok) begin
                        $error("calibration_ok: expected %0b, got %0b",
                               want.calibration_ok, o_out.calibration_ok);
                        fail_count++;
                    end
                    results_owed--;
                    results_seen++;
                end
            end
            if (start && !busy) begin
                expected_pressure.push_back(compensate(i_in, calib_copy));
                beat_taken = 1'b1;
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results owed", cycle_count, results_owed);
            $display("** barometer_pressure_compensation_core: FAILED **");
            $finish;
        end
    end

    initial begin : stim_proc
        t_calib c;
        int ref_code;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset calibration: all zero words, checksum trivially matches
        calib_sets++;
        queue_beat(24'h000000, 24'h000000);
        queue_beat(24'hFFFFFF, 24'hFFFFFF);
        drain();

        // Typical sealed calibration: field extremes and dT around zero
        c = seal_calib(typical_calib(), 1'b0);
        load_calib(c);
        ref_code = int'(c.reference_temperature) * 256;
        queue_beat(24'h000000, 24'h000000);
        queue_beat(24'hFFFFFF, 24'hFFFFFF);
        queue_beat(24'hFFFFFF, 24'h000000);
        queue_beat(24'h000000, 24'hFFFFFF);
        queue_beat(24'd6465444, 24'd8077636);
        queue_beat(24'd6465444, D_W'(ref_code));
        queue_beat(24'd6465444, D_W'(ref_code - 1));
        queue_beat(24'd6465444, D_W'(ref_code + 1));
        queue_beat(24'hFFFFFF, D_W'(ref_code));
        drain();

        // All-ones coefficients: largest intermediates
        c = '1;
        load_calib(c);
        queue_beat(24'hFFFFFF, 24'h000000);
        queue_beat(24'hFFFFFF, 24'hFFFFFF);
        queue_beat(24'h000000, 24'h000000);
        queue_beat(24'h800000, 24'h800000);
        queue_beat(24'h555555, 24'hAAAAAA);
        drain();

        // Typical coefficients with a wrong checksum nibble
        load_calib(seal_calib(typical_calib(), 1'b1));
        queue_beat(24'd6465444, 24'd8077636);
        queue_beat(24'hAAAAAA, 24'h555555);
        queue_beat(24'h000001, 24'hFFFFFE);
        drain();

        // Random calibration sets of several kinds
        for (int ph = 0; ph < RANDOM_SETS; ph++) begin
            case (ph % 5)
                0: c = random_calib();
                1: c = seal_calib(random_calib(), 1'b0);
                2: c = '0;
                3: begin
                    c = '1;
                    c = seal_calib(c, 1'b0);
                end
                default: c = seal_calib(typical_calib(), 1'($urandom_range(1)));
            endcase
            load_calib(c);
            steady_run = (ph == 3);
            if (ph == 6) begin
                // Pause the sender mid-set until the pipe is empty
                queue_random_beats(BEATS_PER_SET / 2);
                drain();
                queue_random_beats(BEATS_PER_SET - BEATS_PER_SET / 2);
            end else begin
                queue_random_beats(BEATS_PER_SET);
            end
            drain();
            steady_run = 1'b0;
        end

        drain();
        $display("Compared %0d compensated pressure beats across %0d calibration sets,",
                 results_seen, calib_sets);
        $display("including zero, all-ones, sealed and corrupted checksum words.");
        if (fail_count == 0 && expected_pressure.size() == 0) begin
            $display("** barometer_pressure_compensation_core: PASSED **");
        end else begin
            $display("%0d mismatches, %0d predictions left over",
                     fail_count, expected_pressure.size());
            $display("** barometer_pressure_compensation_core: FAILED **");
        end
        $finish;
    end

endmodule
